FILE: rtl/dcmt_pkg.sv
// ----------------------------------------------------------------------------
// dcmt_pkg: shared constants and types of the divisor count tally
// Widths of the trial divisor datapath and the control words between the
// sequencer and the bit-serial remainder unit.
// ----------------------------------------------------------------------------
package dcmt_pkg;

  // number width used for counting (low bits of the number field)
  localparam int NUMBER_WIDTH = 17;

  // fixed field widths of the stream words
  localparam int NUM_FIELD_WIDTH = 17;
  localparam int TOTAL_WIDTH     = 8;
  localparam int TALLY_WIDTH     = 17;
  localparam int TARGET_WIDTH    = 8;

  // trial divisor holds floor(sqrt(n)) + 1, the square gets twice that
  localparam int DIV_WIDTH = (NUMBER_WIDTH + 1) / 2 + 1;
  localparam int SQ_WIDTH  = 2 * DIV_WIDTH;
  localparam int CNT_WIDTH = $clog2(NUMBER_WIDTH);

  localparam logic [TOTAL_WIDTH-1:0]  TOTAL_MAX = {TOTAL_WIDTH{1'b1}};
  localparam logic [TALLY_WIDTH-1:0]  TALLY_MAX = {TALLY_WIDTH{1'b1}};
  localparam logic [TARGET_WIDTH-1:0] TARGET_RESET = TARGET_WIDTH'(8);

  // request to the remainder unit
  typedef struct packed {
    logic                    start;
    logic [NUMBER_WIDTH-1:0] dividend;
    logic [DIV_WIDTH-1:0]    divisor;
  } div_cmd_t;

  // answer from the remainder unit
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_sts_t;

endpackage

FILE: rtl/dcmt_rem_unit.sv
// ----------------------------------------------------------------------------
// dcmt_rem_unit: bit-serial remainder unit
// Restoring division, one dividend bit per cycle, most significant first.
// Reports whether the remainder is zero with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module dcmt_rem_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dcmt_pkg::div_cmd_t cmd_i,
  output dcmt_pkg::div_sts_t sts_o
);

  logic                              active_q, active_d;
  logic                              done_q, done_d;
  logic [dcmt_pkg::CNT_WIDTH-1:0]    cnt_q, cnt_d;
  logic [dcmt_pkg::NUMBER_WIDTH-1:0] shift_q, shift_d;
  logic [dcmt_pkg::DIV_WIDTH-1:0]    div_q, div_d;
  logic [dcmt_pkg::DIV_WIDTH-1:0]    rem_q, rem_d;
  logic [dcmt_pkg::DIV_WIDTH:0]      trial;
  logic [dcmt_pkg::DIV_WIDTH:0]      diff;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem_q, shift_q[dcmt_pkg::NUMBER_WIDTH-1]};
  assign diff  = trial - {1'b0, div_q};

  // step sequencing
  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    div_d    = div_q;
    rem_d    = rem_q;
    if (cmd_i.start) begin
      active_d = 1'b1;
      cnt_d    = '0;
      shift_d  = cmd_i.dividend;
      div_d    = cmd_i.divisor;
      rem_d    = '0;
    end else if (active_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[dcmt_pkg::DIV_WIDTH-1:0];
      end else begin
        rem_d = trial[dcmt_pkg::DIV_WIDTH-1:0];
      end
      shift_d = {shift_q[dcmt_pkg::NUMBER_WIDTH-2:0], 1'b0};
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == dcmt_pkg::CNT_WIDTH'(dcmt_pkg::NUMBER_WIDTH - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
  end

  assign sts_o.done     = done_q;
  assign sts_o.rem_zero = (rem_q == '0);

endmodule

FILE: rtl/divisor_count_match_tally.sv
// ----------------------------------------------------------------------------
// divisor_count_match_tally: divisor count by trial division with match tally
//
//   channel  dir  handshake                      payload
//   s_axis   in   s_axis_tvalid/s_axis_tready    tdata number, tuser restart
//   m_axis   out  m_axis_tvalid/m_axis_tready    tdata total, tally; tuser match
//   cfg      in   cfg_valid_i/cfg_ready_o        cfg_data_i target divisors
//
// Each trial divisor b = 1, 2, ... while b*b <= n passes through one compare
// step, NUMBER_WIDTH steps in the bit-serial remainder unit and one update
// step; the result word is registered in a final step, and only after that
// is the next input word taken. Reset clears the tally, sets the target to
// eight and empties the result register; no clearing pass. A new word is taken
// while a result waits; a stalled result holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module divisor_count_match_tally (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] number, [23:17] zero
  input  logic [0:0]  s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] divisor_total, [24:8] match_tally, [31:25] zero
  output logic [0:0]  m_axis_tuser,   // [0] is_match
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [dcmt_pkg::NUMBER_WIDTH-1:0] num_q, num_d;
  logic [dcmt_pkg::DIV_WIDTH-1:0]    b_q, b_d;
  logic [dcmt_pkg::SQ_WIDTH-1:0]     sq_q, sq_d;
  logic [dcmt_pkg::TOTAL_WIDTH-1:0]  count_q, count_d;
  logic [dcmt_pkg::TALLY_WIDTH-1:0]  tally_q, tally_d;
  logic [dcmt_pkg::TARGET_WIDTH-1:0] target_q;
  logic                              out_valid_q, out_valid_d;
  logic [dcmt_pkg::TOTAL_WIDTH-1:0]  out_total_q, out_total_d;
  logic [dcmt_pkg::TALLY_WIDTH-1:0]  out_tally_q, out_tally_d;
  logic                              out_match_q, out_match_d;
  logic [dcmt_pkg::SQ_WIDTH-1:0]     num_ext;
  logic [dcmt_pkg::TOTAL_WIDTH:0]    count_sum;
  logic [1:0]                        count_inc;
  logic                              in_take;
  logic                              match;
  dcmt_pkg::div_cmd_t                div_cmd;
  dcmt_pkg::div_sts_t                div_sts;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign num_ext   = dcmt_pkg::SQ_WIDTH'(num_q);
  assign count_inc = (sq_q == num_ext) ? 2'd1 : 2'd2;
  assign count_sum = {1'b0, count_q} + dcmt_pkg::TOTAL_WIDTH'(count_inc);
  assign match     = (count_q == target_q);

  // remainder request for the current trial divisor
  assign div_cmd.start    = (state_q == ST_CHECK) && (sq_q <= num_ext);
  assign div_cmd.dividend = num_q;
  assign div_cmd.divisor  = b_q;

  dcmt_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .sts_o  (div_sts)
  );

  // sequencer over the trial divisors
  always_comb begin
    state_d     = state_q;
    num_d       = num_q;
    b_d         = b_q;
    sq_d        = sq_q;
    count_d     = count_q;
    tally_d     = tally_q;
    out_valid_d = out_valid_q;
    out_total_d = out_total_q;
    out_tally_d = out_tally_q;
    out_match_d = out_match_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          num_d   = dcmt_pkg::NUMBER_WIDTH'(s_axis_tdata[dcmt_pkg::NUM_FIELD_WIDTH-1:0]);
          b_d     = dcmt_pkg::DIV_WIDTH'(1);
          sq_d    = dcmt_pkg::SQ_WIDTH'(1);
          count_d = '0;
          if (s_axis_tuser[0]) begin
            tally_d = '0;
          end
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq_q <= num_ext) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          if (div_sts.rem_zero) begin
            count_d = count_sum[dcmt_pkg::TOTAL_WIDTH] ? dcmt_pkg::TOTAL_MAX
                                                       : count_sum[dcmt_pkg::TOTAL_WIDTH-1:0];
          end
          // (b+1)^2 = b^2 + 2b + 1
          sq_d    = sq_q + dcmt_pkg::SQ_WIDTH'({b_q, 1'b1});
          b_d     = b_q + 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          if (match && (tally_q != dcmt_pkg::TALLY_MAX)) begin
            tally_d = tally_q + 1'b1;
          end
          out_valid_d = 1'b1;
          out_total_d = count_q;
          out_match_d = match;
          out_tally_d = (match && (tally_q != dcmt_pkg::TALLY_MAX)) ? tally_q + 1'b1
                                                                     : tally_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tally_q     <= '0;
      target_q    <= dcmt_pkg::TARGET_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tally_q     <= tally_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        target_q <= cfg_data_i;
      end
    end
  end

  // working registers and result word
  always_ff @(posedge clk_i) begin
    num_q       <= num_d;
    b_q         <= b_d;
    sq_q        <= sq_d;
    count_q     <= count_d;
    out_total_q <= out_total_d;
    out_tally_q <= out_tally_d;
    out_match_q <= out_match_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_tally_q, out_total_q};
  assign m_axis_tuser  = out_match_q;

endmodule

FILE: tb/sv/tb_divisor_count_match_tally.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_divisor_count_match_tally: self-checking bench of the divisor count tally
// Sends numbers over the input stream and predicts each divisor count, match
// flag and running tally. Every result word is checked field by field in order.
// The run covers directed corner numbers, target extremes, a long output
// stall, and random phases under several targets with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_divisor_count_match_tally;

  localparam int           CLK_HALF     = 5;
  localparam int           RESET_CYCLES = 10;
  localparam int           DRAIN_CYCLES = 40;
  localparam int           HOLD_CYCLES  = 3000;
  localparam int unsigned  CYCLE_LIMIT  = 40000000;
  localparam int           PHASE_ITEMS  = 130;

  // expected content of one result word
  typedef struct packed {
    logic [dcmt_pkg::TOTAL_WIDTH-1:0] total;
    logic                             match;
    logic [dcmt_pkg::TALLY_WIDTH-1:0] tally;
  } tally_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [16:0] number, [23:17] zero
  logic [0:0]  s_axis_tuser;   // [0] restart
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [7:0] divisor_total, [24:8] match_tally, [31:25] zero
  logic [0:0]  m_axis_tuser;   // [0] is_match
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  // bench copy of the block state
  logic [dcmt_pkg::TARGET_WIDTH-1:0] target_copy;
  logic [dcmt_pkg::TALLY_WIDTH-1:0]  tally_copy;
  tally_word_t                       pending_words[$];

  int          mismatch_count;
  int          numbers_sent;
  int          words_checked;
  int          matches_seen;
  int          targets_used;
  int unsigned cycle_count;

  // pacing knobs
  int rx_stall_pct;
  int tx_gap_max;
  int burst_left;
  bit hold_active;
  event hold_off_go;

  divisor_count_match_tally DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  // divisor count by trial division, saturated
  function automatic logic [dcmt_pkg::TOTAL_WIDTH-1:0] count_divisors_of(
    logic [dcmt_pkg::NUMBER_WIDTH-1:0] n);
    int unsigned       cnt;
    longint unsigned   b;
    cnt = 0;
    for (b = 1; b * b <= n; b++) begin
      if (n % b == 0) cnt += (b * b == n) ? 1 : 2;
    end
    if (cnt > dcmt_pkg::TOTAL_MAX) cnt = dcmt_pkg::TOTAL_MAX;
    return cnt[dcmt_pkg::TOTAL_WIDTH-1:0];
  endfunction

  // advance the tally copy and queue the word this number should give
  task automatic predict_tally_word(logic [dcmt_pkg::NUM_FIELD_WIDTH-1:0] number,
                                    logic restart);
    tally_word_t w;
    if (restart) tally_copy = '0;
    w.total = count_divisors_of(number[dcmt_pkg::NUMBER_WIDTH-1:0]);
    w.match = (w.total == target_copy);
    if (w.match && tally_copy != dcmt_pkg::TALLY_MAX) tally_copy = tally_copy + 1'b1;
    w.tally = tally_copy;
    pending_words.push_back(w);
  endtask

  task automatic report_mismatch(string what, longint unsigned exp, longint unsigned got);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp, got);
  endtask

  // offer one number and wait for it to be taken
  task automatic send_word(logic [dcmt_pkg::NUM_FIELD_WIDTH-1:0] number, logic restart);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, number};
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tally_word(number, restart);
    numbers_sent++;
  endtask

  task automatic idle_sender(int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // send in bursts with random gaps between them
  task automatic send_paced(logic [dcmt_pkg::NUM_FIELD_WIDTH-1:0] number, logic restart);
    if (burst_left == 0) begin
      if (tx_gap_max > 0) idle_sender($urandom_range(1, tx_gap_max));
      burst_left = $urandom_range(1, 6);
    end
    burst_left--;
    send_word(number, restart);
  endtask

  // stop offering and let every expected word come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_target(logic [dcmt_pkg::TARGET_WIDTH-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    target_copy = value;
    targets_used++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly small numbers to keep the run short, a few across the full range
  function automatic logic [dcmt_pkg::NUM_FIELD_WIDTH-1:0] pick_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return dcmt_pkg::NUM_FIELD_WIDTH'($urandom_range(1, 1023));
    else if (r < 97) return dcmt_pkg::NUM_FIELD_WIDTH'($urandom_range(1, 4095));
    else return dcmt_pkg::NUM_FIELD_WIDTH'($urandom_range(0, 131071));
  endfunction

  // result checker
  always @(posedge clk_i) begin
    tally_word_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, total", 0, m_axis_tdata[7:0]);
      end else begin
        exp = pending_words.pop_front();
        words_checked++;
        if (m_axis_tuser[0]) matches_seen++;
        if (m_axis_tdata[7:0] !== exp.total)
          report_mismatch("divisor_total", exp.total, m_axis_tdata[7:0]);
        if (m_axis_tuser[0] !== exp.match)
          report_mismatch("is_match", exp.match, m_axis_tuser[0]);
        if (m_axis_tdata[24:8] !== exp.tally)
          report_mismatch("match_tally", exp.tally, m_axis_tdata[24:8]);
      end
    end
  end

  // receiver stalls in random runs, and throughout a hold-off
  initial begin
    int run_left;
    bit run_ready;
    m_axis_tready = 1'b0;
    run_left = 0;
    run_ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        run_ready = ($urandom_range(0, 99) >= rx_stall_pct);
        run_left  = $urandom_range(1, 8);
      end
      run_left--;
      m_axis_tready <= run_ready && !hold_active;
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_off_go);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_active = 1'b0;
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // corner numbers under the reset target, restart included
  task automatic test_directed_counts();
    send_word(17'd24, 1'b0);       // eight divisors, first match
    send_word(17'd30, 1'b0);
    send_word(17'd1, 1'b0);        // number one
    send_word(17'd0, 1'b0);        // number zero
    send_word(17'd4, 1'b0);        // small square
    send_word(17'd65536, 1'b0);    // large square
    send_word(17'd83160, 1'b0);    // 128 divisors
    send_word(17'd100001, 1'b0);
    send_word(17'd131071, 1'b1);   // all ones, prime, with restart
    send_word(17'd120, 1'b0);
    send_word(17'd54, 1'b0);
    send_word(17'd40, 1'b1);       // restart on a match
  endtask

  // target at its extremes and above any reachable divisor count
  task automatic test_target_extremes();
    write_target(8'd0);
    send_word(17'd0, 1'b0);
    send_word(17'd1, 1'b0);
    send_word(17'd0, 1'b1);
    write_target(8'd255);
    send_word(17'd83160, 1'b0);
    write_target(8'd128);
    send_word(17'd83160, 1'b0);
    send_word(17'd65535, 1'b0);
    write_target(8'd1);
    send_word(17'd1, 1'b0);
    send_word(17'd1, 1'b1);
    write_target(8'd2);
    send_word(17'd131071, 1'b0);
    send_word(17'd2, 1'b0);
    send_word(17'd3, 1'b0);
  endtask

  // output held off while input keeps coming, block fills and stalls
  task automatic test_input_backpressure();
    int i;
    write_target(8'd4);
    -> hold_off_go;
    for (i = 0; i < 10; i++)
      send_word(dcmt_pkg::NUM_FIELD_WIDTH'($urandom_range(1, 200)), 1'b0);
  endtask

  // random phases, each with its own target and pacing
  task automatic test_random_phases();
    logic [dcmt_pkg::TARGET_WIDTH-1:0] phase_targets[8];
    int p, i;
    phase_targets = '{8'd8, 8'd4, 8'd2, 8'd255, 8'd6, 8'd1, 8'd12, 8'd0};
    phase_targets[7] = dcmt_pkg::TARGET_WIDTH'($urandom_range(1, 255));
    for (p = 0; p < 8; p++) begin
      write_target(phase_targets[p]);
      case (p % 4)
        0: begin rx_stall_pct = 0;  tx_gap_max = 0;   end
        1: begin rx_stall_pct = 30; tx_gap_max = 20;  end
        2: begin rx_stall_pct = 70; tx_gap_max = 400; end
        default: begin rx_stall_pct = 15; tx_gap_max = 60; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++)
        send_paced(pick_number(), ($urandom_range(0, 99) < 4));
    end
  endtask

  // test sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    target_copy   = dcmt_pkg::TARGET_RESET;
    tally_copy    = '0;
    mismatch_count = 0;
    numbers_sent   = 0;
    words_checked  = 0;
    matches_seen   = 0;
    targets_used   = 0;
    rx_stall_pct   = 25;
    tx_gap_max     = 0;
    burst_left     = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_counts();
    test_target_extremes();
    test_input_backpressure();
    test_random_phases();
    wait_drained();

    $display("Run covered %0d numbers, %0d result words checked, %0d matches.",
             numbers_sent, words_checked, matches_seen);
    $display("Target written %0d times, including 0, 1 and 255, plus a %0d-cycle hold-off.",
             targets_used, HOLD_CYCLES);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
